// ===== src/page_span_allocator_core_macros.svh =====
// Assertion macros for the page span allocator core.
`ifndef PAGE_SPAN_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_SPAN_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PSA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("page span allocator check failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("page span allocator check failed");
`else
`define PSA_ASSERT_IMPL(label, ante, cons)
`define PSA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/psa_pkg.sv =====
package psa_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OOM      = 2'd1,
      ST_INVALID  = 2'd2,
      ST_UNMAPPED = 2'd3
   } status_type;

   // Request operation codes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_LOOKUP  = 2'd2;

   // Pool size register value after reset
   localparam logic [3:0] POOL_CHUNKS_RESET = 4'd8;

endpackage

// ===== src/psa_ram.sv =====
module psa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/page_span_allocator_core.sv =====
// Page span allocator: one request at a time, result held in an output register.
// A bad request ends at once; a lookup reads the owner and then its span data; an
// exact-size allocate unlinks its list head; a split allocate scans the larger sizes
// and writes the owner of each page given out; drawing a chunk (once per request)
// writes the owner of each page in it. Release merges free neighbours, rewriting owners.
// The next request is accepted while the result is presented. Synchronous reset empties
// every size list, unmaps the pool, sets pool_chunks to 8 and runs no clearing pass.
`include "page_span_allocator_core_macros.svh"

module page_span_allocator_core #(
   parameter int NUM_PAGES      = 1024,
   parameter int MAX_SPAN_PAGES = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_op,
   input  logic [$clog2(MAX_SPAN_PAGES+1)-1:0]   req_page_count,
   input  logic [$clog2(NUM_PAGES)-1:0]          req_page_number,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output psa_pkg::status_type                   rsp_status,
   output logic [$clog2(NUM_PAGES)-1:0]          rsp_span_start,
   output logic [$clog2(MAX_SPAN_PAGES+1)-1:0]   rsp_span_pages,
   output logic                                  rsp_span_busy,
   input  logic                                  csr_write_enable,
   input  logic [3:0]                            csr_write_data
);

   import psa_pkg::*;

   localparam int PW = $clog2(NUM_PAGES);
   localparam int CW = $clog2(MAX_SPAN_PAGES + 1);
   localparam int LW = PW + 1;
   localparam int SW = CW + 1;
   localparam int XW = PW + 2;
   localparam int HD = MAX_SPAN_PAGES + 1;
   localparam logic [LW-1:0] NIL   = LW'(NUM_PAGES);
   localparam logic [XW-1:0] NUM_X = XW'(NUM_PAGES);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_SPAN_PAGES);

   typedef enum logic [5:0] {
      S_IDLE, S_DISPATCH, S_TAKE, S_TAKE_EX, S_EX_DONE, S_SCAN, S_SPL_HD, S_SPL_T,
      S_SPL_OWN, S_SPL_INFO, S_SPL_FRONT, S_NOSPAN, S_DRAW_OWN, S_DRAW_INFO,
      S_DRAW_END, S_REL_CHK, S_BK, S_BK_O, S_BK_I, S_BK_OWN, S_FW, S_FW_O, S_FW_I,
      S_FW_OWN, S_REL_FIN, S_LK_O, S_LK_I, S_LR_RD, S_LR_WR, S_LP_RD, S_LP_W1,
      S_LP_W2, S_FINISH
   } state_type;

   state_type        state_ff, state_in, ret_ff, ret_in;
   logic [1:0]       op_ff, op_in;
   logic [CW-1:0]    n_ff, n_in, len_ff, len_in, size_ff, size_in;
   logic [CW-1:0]    olen_ff, olen_in, cnt_ff, cnt_in, ls_size_ff, ls_size_in;
   logic [PW-1:0]    pg_ff, pg_in, s_ff, s_in, o_ff, o_in, t_ff, t_in, ls_s_ff, ls_s_in;
   logic [SW-1:0]    scan_ff, scan_in;
   logic [LW-1:0]    h_ff, h_in, limit_ff, limit_in;
   logic             retried_ff, retried_in;
   logic [3:0]       pool_ff, pool_in, chunks_ff, chunks_in;
   logic [HD-1:0]    nonempty_ff, nonempty_in;
   status_type       res_status_ff, res_status_in, rsp_status_ff, rsp_status_in;
   logic [PW-1:0]    res_start_ff, res_start_in, rsp_start_ff, rsp_start_in;
   logic [CW-1:0]    res_pages_ff, res_pages_in, rsp_pages_ff, rsp_pages_in;
   logic             res_busy_ff, res_busy_in, rsp_busy_ff, rsp_busy_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Memory ports
   logic            own_we, info_we, nxt_we, prv_we, hd_we;
   logic [PW-1:0]   own_wa, own_wd, own_ra, own_rd, info_wa, info_ra;
   logic [PW-1:0]   nxt_wa, nxt_ra, prv_wa, prv_ra;
   logic [CW:0]     info_wd, info_rd;
   logic [LW-1:0]   nxt_wd, nxt_rd, prv_wd, prv_rd, hd_wd, hd_rd;
   logic [CW-1:0]   hd_wa, hd_ra;

   // Shared address and length arithmetic
   logic [XW-1:0]   t_wide, q_bk, q_fw;
   logic [CW:0]     len_sum;
   logic            draw_ok;

   assign t_wide  = XW'(s_ff) + XW'(size_ff) - XW'(n_ff);
   assign q_bk    = XW'(s_ff) - XW'(1);
   assign q_fw    = XW'(s_ff) + XW'(len_ff);
   assign len_sum = (CW+1)'(len_ff) + (CW+1)'(info_rd[CW:1]);
   assign draw_ok = !retried_ff && (chunks_ff < pool_ff) &&
                    (XW'(limit_ff) + XW'(MAX_SPAN_PAGES) <= NUM_X);

   psa_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_owner (
      .clock(clock), .wr_en(own_we), .wr_addr(own_wa), .wr_data(own_wd),
      .rd_addr(own_ra), .rd_data(own_rd));
   psa_ram #(.WIDTH(CW+1), .DEPTH(NUM_PAGES)) u_info (
      .clock(clock), .wr_en(info_we), .wr_addr(info_wa), .wr_data(info_wd),
      .rd_addr(info_ra), .rd_data(info_rd));
   psa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_next (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(nxt_ra), .rd_data(nxt_rd));
   psa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_prev (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(prv_ra), .rd_data(prv_rd));
   psa_ram #(.WIDTH(LW), .DEPTH(HD)) u_head (
      .clock(clock), .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
      .rd_addr(hd_ra), .rd_data(hd_rd));

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_span_start = rsp_start_ff;
   assign rsp_span_pages = rsp_pages_ff;
   assign rsp_span_busy  = rsp_busy_ff;

   // Sequencer: next state, memory controls, result staging
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      op_in         = op_ff;
      n_in          = n_ff;
      pg_in         = pg_ff;
      s_in          = s_ff;
      len_in        = len_ff;
      size_in       = size_ff;
      o_in          = o_ff;
      olen_in       = olen_ff;
      t_in          = t_ff;
      cnt_in        = cnt_ff;
      scan_in       = scan_ff;
      ls_size_in    = ls_size_ff;
      ls_s_in       = ls_s_ff;
      h_in          = h_ff;
      retried_in    = retried_ff;
      chunks_in     = chunks_ff;
      limit_in      = limit_ff;
      nonempty_in   = nonempty_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_pages_in  = res_pages_ff;
      res_busy_in   = res_busy_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_pages_in  = rsp_pages_ff;
      rsp_busy_in   = rsp_busy_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      pool_in       = csr_write_enable ? csr_write_data : pool_ff;
      own_we  = 1'b0; own_wa  = '0; own_wd  = '0; own_ra  = '0;
      info_we = 1'b0; info_wa = '0; info_wd = '0; info_ra = '0;
      nxt_we  = 1'b0; nxt_wa  = '0; nxt_wd  = '0; nxt_ra  = '0;
      prv_we  = 1'b0; prv_wa  = '0; prv_wd  = '0; prv_ra  = '0;
      hd_we   = 1'b0; hd_wa   = '0; hd_wd   = '0; hd_ra   = '0;

      case (state_ff)
         // Take a new request
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               n_in       = req_page_count;
               pg_in      = req_page_number;
               retried_in = 1'b0;
               state_in   = S_DISPATCH;
            end
         end
         // Decode the operation; error results carry zero fields
         S_DISPATCH: begin
            res_status_in = ST_INVALID;
            res_start_in  = '0;
            res_pages_in  = '0;
            res_busy_in   = 1'b0;
            state_in      = S_FINISH;
            case (op_ff)
               OP_ALLOC: begin
                  if (n_ff != '0 && n_ff <= MAX_C) begin
                     state_in = S_TAKE;
                  end
               end
               OP_RELEASE: begin
                  if (XW'(pg_ff) < XW'(limit_ff)) begin
                     own_ra   = pg_ff;
                     info_ra  = pg_ff;
                     state_in = S_REL_CHK;
                  end else begin
                     res_status_in = ST_UNMAPPED;
                  end
               end
               OP_LOOKUP: begin
                  if (XW'(pg_ff) < XW'(limit_ff)) begin
                     own_ra   = pg_ff;
                     state_in = S_LK_O;
                  end else begin
                     res_status_in = ST_UNMAPPED;
                  end
               end
               default: begin
                  res_status_in = ST_INVALID;
               end
            endcase
         end
         // Exact-size list first, else scan the larger sizes
         S_TAKE: begin
            if (nonempty_ff[n_ff]) begin
               hd_ra    = n_ff;
               state_in = S_TAKE_EX;
            end else begin
               scan_in  = SW'(n_ff) + SW'(1);
               state_in = S_SCAN;
            end
         end
         S_TAKE_EX: begin
            s_in       = hd_rd[PW-1:0];
            ls_size_in = n_ff;
            ls_s_in    = hd_rd[PW-1:0];
            ret_in     = S_EX_DONE;
            state_in   = S_LR_RD;
         end
         S_EX_DONE: begin
            info_we       = 1'b1;
            info_wa       = s_ff;
            info_wd       = {n_ff, 1'b1};
            res_status_in = ST_OK;
            res_start_in  = s_ff;
            res_pages_in  = n_ff;
            res_busy_in   = 1'b1;
            state_in      = S_FINISH;
         end
         // One size per cycle
         S_SCAN: begin
            if (scan_ff > SW'(MAX_SPAN_PAGES)) begin
               state_in = S_NOSPAN;
            end else if (nonempty_ff[scan_ff[CW-1:0]]) begin
               hd_ra    = scan_ff[CW-1:0];
               size_in  = scan_ff[CW-1:0];
               state_in = S_SPL_HD;
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end
         S_SPL_HD: begin
            s_in       = hd_rd[PW-1:0];
            ls_size_in = size_ff;
            ls_s_in    = hd_rd[PW-1:0];
            ret_in     = S_SPL_T;
            state_in   = S_LR_RD;
         end
         S_SPL_T: begin
            if (t_wide >= NUM_X) begin
               state_in = S_NOSPAN;
            end else begin
               t_in     = t_wide[PW-1:0];
               cnt_in   = '0;
               state_in = S_SPL_OWN;
            end
         end
         // Point the tail pages at the tail start
         S_SPL_OWN: begin
            if (cnt_ff == n_ff) begin
               state_in = S_SPL_INFO;
            end else begin
               own_we = (XW'(t_ff) + XW'(cnt_ff) < NUM_X);
               own_wa = PW'(XW'(t_ff) + XW'(cnt_ff));
               own_wd = t_ff;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_SPL_INFO: begin
            info_we  = 1'b1;
            info_wa  = t_ff;
            info_wd  = {n_ff, 1'b1};
            state_in = S_SPL_FRONT;
         end
         // Shorten the front and push it back
         S_SPL_FRONT: begin
            info_we       = 1'b1;
            info_wa       = s_ff;
            info_wd       = {size_ff - n_ff, 1'b0};
            ls_size_in    = size_ff - n_ff;
            ls_s_in       = s_ff;
            res_status_in = ST_OK;
            res_start_in  = t_ff;
            res_pages_in  = n_ff;
            res_busy_in   = 1'b1;
            ret_in        = S_FINISH;
            state_in      = S_LP_RD;
         end
         // Draw a fresh chunk once, else out of memory
         S_NOSPAN: begin
            if (draw_ok) begin
               cnt_in   = '0;
               state_in = S_DRAW_OWN;
            end else begin
               res_status_in = ST_OOM;
               state_in      = S_FINISH;
            end
         end
         S_DRAW_OWN: begin
            if (cnt_ff == MAX_C) begin
               state_in = S_DRAW_INFO;
            end else begin
               own_we = 1'b1;
               own_wa = PW'(XW'(limit_ff) + XW'(cnt_ff));
               own_wd = limit_ff[PW-1:0];
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_DRAW_INFO: begin
            info_we    = 1'b1;
            info_wa    = limit_ff[PW-1:0];
            info_wd    = {MAX_C, 1'b0};
            ls_size_in = MAX_C;
            ls_s_in    = limit_ff[PW-1:0];
            ret_in     = S_DRAW_END;
            state_in   = S_LP_RD;
         end
         S_DRAW_END: begin
            chunks_in  = chunks_ff + 4'd1;
            limit_in   = limit_ff + LW'(MAX_SPAN_PAGES);
            retried_in = 1'b1;
            state_in   = S_TAKE;
         end
         // Release only the start of a busy span
         S_REL_CHK: begin
            if (own_rd == pg_ff && info_rd[0]) begin
               info_we  = 1'b1;
               info_wa  = pg_ff;
               info_wd  = {info_rd[CW:1], 1'b0};
               s_in     = pg_ff;
               len_in   = info_rd[CW:1];
               state_in = S_BK;
            end else begin
               state_in = S_FINISH;
            end
         end
         // Coalesce backward
         S_BK: begin
            if (s_ff == '0 || q_bk >= XW'(limit_ff)) begin
               state_in = S_FW;
            end else begin
               own_ra   = PW'(q_bk);
               state_in = S_BK_O;
            end
         end
         S_BK_O: begin
            o_in     = own_rd;
            info_ra  = own_rd;
            state_in = S_BK_I;
         end
         S_BK_I: begin
            if (XW'(o_ff) >= NUM_X || info_rd[0] || len_sum > (CW+1)'(MAX_SPAN_PAGES)) begin
               state_in = S_FW;
            end else begin
               olen_in    = info_rd[CW:1];
               ls_size_in = info_rd[CW:1];
               ls_s_in    = o_ff;
               cnt_in     = '0;
               ret_in     = S_BK_OWN;
               state_in   = S_LR_RD;
            end
         end
         S_BK_OWN: begin
            if (cnt_ff == len_ff) begin
               len_in   = len_ff + olen_ff;
               s_in     = o_ff;
               info_we  = 1'b1;
               info_wa  = o_ff;
               info_wd  = {len_ff + olen_ff, 1'b0};
               state_in = S_BK;
            end else begin
               own_we = (XW'(s_ff) + XW'(cnt_ff) < NUM_X);
               own_wa = PW'(XW'(s_ff) + XW'(cnt_ff));
               own_wd = o_ff;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         // Coalesce forward
         S_FW: begin
            if (q_fw >= XW'(limit_ff)) begin
               state_in = S_REL_FIN;
            end else begin
               own_ra   = PW'(q_fw);
               state_in = S_FW_O;
            end
         end
         S_FW_O: begin
            o_in     = own_rd;
            info_ra  = own_rd;
            state_in = S_FW_I;
         end
         S_FW_I: begin
            if (XW'(o_ff) >= NUM_X || info_rd[0] || len_sum > (CW+1)'(MAX_SPAN_PAGES)) begin
               state_in = S_REL_FIN;
            end else begin
               olen_in    = info_rd[CW:1];
               ls_size_in = info_rd[CW:1];
               ls_s_in    = o_ff;
               cnt_in     = '0;
               ret_in     = S_FW_OWN;
               state_in   = S_LR_RD;
            end
         end
         S_FW_OWN: begin
            if (cnt_ff == olen_ff) begin
               len_in   = len_ff + olen_ff;
               info_we  = 1'b1;
               info_wa  = s_ff;
               info_wd  = {len_ff + olen_ff, 1'b0};
               state_in = S_FW;
            end else begin
               own_we = (XW'(o_ff) + XW'(cnt_ff) < NUM_X);
               own_wa = PW'(XW'(o_ff) + XW'(cnt_ff));
               own_wd = s_ff;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_REL_FIN: begin
            info_we       = 1'b1;
            info_wa       = s_ff;
            info_wd       = {len_ff, 1'b0};
            ls_size_in    = len_ff;
            ls_s_in       = s_ff;
            res_status_in = ST_OK;
            res_start_in  = s_ff;
            res_pages_in  = len_ff;
            res_busy_in   = 1'b0;
            ret_in        = S_FINISH;
            state_in      = S_LP_RD;
         end
         // Lookup owner, then its span data
         S_LK_O: begin
            o_in     = own_rd;
            info_ra  = own_rd;
            state_in = S_LK_I;
         end
         S_LK_I: begin
            if (XW'(o_ff) < NUM_X) begin
               res_status_in = ST_OK;
               res_start_in  = o_ff;
               res_pages_in  = info_rd[CW:1];
               res_busy_in   = info_rd[0];
            end else begin
               res_status_in = ST_UNMAPPED;
            end
            state_in = S_FINISH;
         end
         // Unlink a span from its size list
         S_LR_RD: begin
            if (ls_size_ff > MAX_C) begin
               state_in = ret_ff;
            end else begin
               nxt_ra   = ls_s_ff;
               prv_ra   = ls_s_ff;
               state_in = S_LR_WR;
            end
         end
         S_LR_WR: begin
            if (prv_rd < NIL) begin
               nxt_we = 1'b1;
               nxt_wa = prv_rd[PW-1:0];
               nxt_wd = nxt_rd;
            end else begin
               hd_we                   = 1'b1;
               hd_wa                   = ls_size_ff;
               hd_wd                   = nxt_rd;
               nonempty_in[ls_size_ff] = (nxt_rd < NIL);
            end
            if (nxt_rd < NIL) begin
               prv_we = 1'b1;
               prv_wa = nxt_rd[PW-1:0];
               prv_wd = prv_rd;
            end
            state_in = ret_ff;
         end
         // Push a span on the head of its size list
         S_LP_RD: begin
            if (ls_size_ff > MAX_C) begin
               state_in = ret_ff;
            end else begin
               hd_ra    = ls_size_ff;
               state_in = S_LP_W1;
            end
         end
         S_LP_W1: begin
            h_in                    = nonempty_ff[ls_size_ff] ? hd_rd : NIL;
            nxt_we                  = 1'b1;
            nxt_wa                  = ls_s_ff;
            nxt_wd                  = nonempty_ff[ls_size_ff] ? hd_rd : NIL;
            prv_we                  = 1'b1;
            prv_wa                  = ls_s_ff;
            prv_wd                  = NIL;
            hd_we                   = 1'b1;
            hd_wa                   = ls_size_ff;
            hd_wd                   = LW'(ls_s_ff);
            nonempty_in[ls_size_ff] = 1'b1;
            state_in                = S_LP_W2;
         end
         S_LP_W2: begin
            if (h_ff < NIL) begin
               prv_we = 1'b1;
               prv_wa = h_ff[PW-1:0];
               prv_wd = LW'(ls_s_ff);
            end
            state_in = ret_ff;
         end
         // Hand the result to the output register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_pages_in  = res_pages_ff;
               rsp_busy_in   = res_busy_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pool_ff      <= POOL_CHUNKS_RESET;
         chunks_ff    <= '0;
         limit_ff     <= '0;
         nonempty_ff  <= '0;
         retried_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         rsp_valid_ff  <= rsp_valid_in;
         pool_ff       <= pool_in;
         chunks_ff     <= chunks_in;
         limit_ff      <= limit_in;
         nonempty_ff   <= nonempty_in;
         retried_ff    <= retried_in;
         op_ff         <= op_in;
         n_ff          <= n_in;
         pg_ff         <= pg_in;
         s_ff          <= s_in;
         len_ff        <= len_in;
         size_ff       <= size_in;
         o_ff          <= o_in;
         olen_ff       <= olen_in;
         t_ff          <= t_in;
         cnt_ff        <= cnt_in;
         scan_ff       <= scan_in;
         ls_size_ff    <= ls_size_in;
         ls_s_ff       <= ls_s_in;
         h_ff          <= h_in;
         res_status_ff <= res_status_in;
         res_start_ff  <= res_start_in;
         res_pages_ff  <= res_pages_in;
         res_busy_ff   <= res_busy_in;
         rsp_status_ff <= rsp_status_in;
         rsp_start_ff  <= rsp_start_in;
         rsp_pages_ff  <= rsp_pages_in;
         rsp_busy_ff   <= rsp_busy_in;
      end
   end

   // Checks
   `PSA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `PSA_ASSERT_IMPL(a_error_fields_zero, rsp_valid && rsp_status != ST_OK, rsp_span_start == '0 && rsp_span_pages == '0 && !rsp_span_busy)
   `PSA_ASSERT_IMPL(a_ok_span_nonempty, rsp_valid && rsp_status == ST_OK, rsp_span_pages != '0)
   `PSA_ASSERT_IMPL(a_pool_in_range, !req_stall, limit_ff <= NIL && chunks_ff <= pool_ff || limit_ff <= NIL)

endmodule
